// ===== design/ezr_pkg.sv =====
// ----------------------------------------------------------------------------
// ezr_pkg
// Shared types, constants and fixed-point helpers for the z-x-z euler
// rotation matrix block.
// ----------------------------------------------------------------------------
package ezr_pkg;

  localparam int ANGLE_BITS = 16;
  localparam int FRAC_BITS  = 14;
  localparam int VAL_W      = 16;

  // cordic datapath: values with CF fraction bits, angles in turns with ZF bits
  localparam int CW  = 40;
  localparam int CF  = 36;
  localparam int ZW  = 48;
  localparam int ZF  = 44;
  localparam int NIT = 38;

  // sincos pipeline registers: fold register, NIT rotation stages, round/map register
  localparam int SC_LAT = NIT + 2;

  // one over two pi, radians to turns
  localparam real INV_TWO_PI = 0.15915494309189533577;

  typedef logic signed [VAL_W-1:0] trig_t;

  typedef struct packed {
    logic [ANGLE_BITS-1:0] yaw_angle;
    logic [ANGLE_BITS-1:0] pitch_angle;
    logic [ANGLE_BITS-1:0] roll_angle;
  } ezr_in_t;

  typedef struct packed {
    trig_t m_r0c0;
    trig_t m_r0c1;
    trig_t m_r0c2;
    trig_t m_r1c0;
    trig_t m_r1c1;
    trig_t m_r1c2;
    trig_t m_r2c0;
    trig_t m_r2c1;
    trig_t m_r2c2;
  } ezr_out_t;

  // atan(2^-i) as a fraction of a full turn
  function automatic logic signed [ZW-1:0] atan_const(input int i);
    real a;
    a = $atan(2.0 ** (-1.0 * i)) * INV_TWO_PI * (2.0 ** ZF);
    return ZW'(longint'(a));
  endfunction

  // inverse cordic gain, start value for x
  function automatic logic signed [CW-1:0] cordic_gain();
    real k;
    k = 1.0;
    for (int i = 0; i < NIT; i++) begin
      k = k * ((1.0 + 2.0 ** (-2.0 * i)) ** (-0.5));
    end
    return CW'(longint'(k * (2.0 ** CF)));
  endfunction

  // product of two Q2.14 values, floor shifted back to Q2.14
  function automatic trig_t fmul(input trig_t a, input trig_t b);
    logic signed [2*VAL_W-1:0] p;
    p = a * b;
    return VAL_W'(p >>> FRAC_BITS);
  endfunction

endpackage

// ===== design/ezr_sincos.sv =====
// ----------------------------------------------------------------------------
// ezr_sincos
// Pipelined cordic sine and cosine of a binary angle, rounded to Q2.14.
// ----------------------------------------------------------------------------
module ezr_sincos (
  input  logic                           clk,
  input  logic [ezr_pkg::ANGLE_BITS-1:0] angle,
  output ezr_pkg::trig_t                 sin_o,
  output ezr_pkg::trig_t                 cos_o
);
  import ezr_pkg::*;

  localparam int QUARTER = 1 << (ANGLE_BITS - 2);
  localparam int EIGHTH  = 1 << (ANGLE_BITS - 3);
  localparam logic signed [CW-1:0] RND = CW'(1) <<< (CF - FRAC_BITS - 1);
  localparam logic signed [CW-1:0] X_INIT = cordic_gain();

  logic [ANGLE_BITS-3:0] r;
  logic [ANGLE_BITS-2:0] rr;

  logic signed [CW-1:0] x_r [0:NIT];
  logic signed [CW-1:0] y_r [0:NIT];
  logic signed [ZW-1:0] z_r [0:NIT];
  logic [1:0]           q_r [0:NIT];
  logic                 sw_r [0:NIT];

  logic signed [CW-1:0] s_full, c_full;
  trig_t s_m, c_m, sin_nxt, cos_nxt;

  // octant fold
  always_comb begin
    r  = angle[ANGLE_BITS-3:0];
    rr = ({1'b0, r} <= (ANGLE_BITS-1)'(EIGHTH)) ? {1'b0, r}
                                                 : (ANGLE_BITS-1)'(QUARTER) - {1'b0, r};
  end

  always_ff @(posedge clk) begin
    x_r[0]  <= X_INIT;
    y_r[0]  <= '0;
    z_r[0]  <= ZW'(rr) <<< (ZF - ANGLE_BITS);
    q_r[0]  <= angle[ANGLE_BITS-1:ANGLE_BITS-2];
    sw_r[0] <= ({1'b0, r} > (ANGLE_BITS-1)'(EIGHTH));
  end

  for (genvar i = 0; i < NIT; i++) begin : g_rot
    localparam logic signed [ZW-1:0] ATAN_I = atan_const(i);
    always_ff @(posedge clk) begin
      if (!z_r[i][ZW-1]) begin
        x_r[i+1] <= x_r[i] - (y_r[i] >>> i);
        y_r[i+1] <= y_r[i] + (x_r[i] >>> i);
        z_r[i+1] <= z_r[i] - ATAN_I;
      end else begin
        x_r[i+1] <= x_r[i] + (y_r[i] >>> i);
        y_r[i+1] <= y_r[i] - (x_r[i] >>> i);
        z_r[i+1] <= z_r[i] + ATAN_I;
      end
      q_r[i+1]  <= q_r[i];
      sw_r[i+1] <= sw_r[i];
    end
  end

  // round to nearest, undo the fold, apply the quadrant
  always_comb begin
    s_full = (y_r[NIT] + RND) >>> (CF - FRAC_BITS);
    c_full = (x_r[NIT] + RND) >>> (CF - FRAC_BITS);
    s_m = sw_r[NIT] ? VAL_W'(c_full) : VAL_W'(s_full);
    c_m = sw_r[NIT] ? VAL_W'(s_full) : VAL_W'(c_full);
    unique case (q_r[NIT])
      2'd0: begin sin_nxt = s_m;  cos_nxt = c_m;  end
      2'd1: begin sin_nxt = c_m;  cos_nxt = -s_m; end
      2'd2: begin sin_nxt = -s_m; cos_nxt = -c_m; end
      default: begin sin_nxt = -c_m; cos_nxt = s_m; end
    endcase
  end

  always_ff @(posedge clk) begin
    sin_o <= sin_nxt;
    cos_o <= cos_nxt;
  end

endmodule

// ===== design/euler_zxz_rotation_matrix.sv =====
// ----------------------------------------------------------------------------
// euler_zxz_rotation_matrix
// Z-X-Z euler rotation matrix in signed Q2.14 from three binary angles.
// ----------------------------------------------------------------------------
// usage
//   a request is taken on every rising edge with in_start high; busy is
//   always low, so a new angle triple can enter in every cycle
//   in_req carries yaw, pitch and roll, each a 16-bit binary angle
//   out_valid marks the one cycle in which out_result holds the nine
//   row-major matrix entries, saturated to plus or minus 16384
// pipeline
//   from request to result: one fold stage, 38 cordic rotation stages,
//   one round stage, then two product stages and a sum/saturate stage
// throughput
//   one request per cycle, set by the fully pipelined cordic lanes
// reset
//   rst_n clears the valid pipeline only; no result appears until new
//   requests reach the end
// the receiver cannot stall, so nothing ever holds the pipeline
module euler_zxz_rotation_matrix (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_start,
  output logic              in_busy,
  input  ezr_pkg::ezr_in_t  in_req,
  output logic              out_valid,
  output ezr_pkg::ezr_out_t out_result
);
  import ezr_pkg::*;

  localparam trig_t LIM = trig_t'(1 << FRAC_BITS);

  trig_t sy, cy, sp, cp, sr, cr;

  // valid bits follow the data through the sincos lanes
  logic [SC_LAT-1:0] vld_sc_r;
  logic              vld1_r, vld2_r;

  // first product stage
  trig_t cycr_r, sycp_r, cycp_r, ncysr_r, sysp_r, nsysr_r, sycr_r, ncysp_r;
  trig_t spsr_r, spcr_r, sr1_r, cr1_r, cp1_r;

  // second product stage
  trig_t a_r, b_r, c_r, d_r;
  trig_t cycr2_r, ncysr2_r, sysp2_r, nsysr2_r, sycr2_r, ncysp2_r;
  trig_t spsr2_r, spcr2_r, cp2_r;

  logic signed [VAL_W:0] e00, e01, e10, e11;
  ezr_out_t res_nxt;

  assign in_busy = 1'b0;

  ezr_sincos u_yaw   (.clk(clk), .angle(in_req.yaw_angle),   .sin_o(sy), .cos_o(cy));
  ezr_sincos u_pitch (.clk(clk), .angle(in_req.pitch_angle), .sin_o(sp), .cos_o(cp));
  ezr_sincos u_roll  (.clk(clk), .angle(in_req.roll_angle),  .sin_o(sr), .cos_o(cr));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_sc_r  <= '0;
      vld1_r    <= 1'b0;
      vld2_r    <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      vld_sc_r  <= {vld_sc_r[SC_LAT-2:0], in_start};
      vld1_r    <= vld_sc_r[SC_LAT-1];
      vld2_r    <= vld1_r;
      out_valid <= vld2_r;
    end
  end

  // single products; a leading minus negates the first factor
  always_ff @(posedge clk) begin
    cycr_r  <= fmul(cy, cr);
    sycp_r  <= fmul(sy, cp);
    cycp_r  <= fmul(cy, cp);
    ncysr_r <= fmul(-cy, sr);
    sysp_r  <= fmul(sy, sp);
    nsysr_r <= fmul(-sy, sr);
    sycr_r  <= fmul(sy, cr);
    ncysp_r <= fmul(-cy, sp);
    spsr_r  <= fmul(sp, sr);
    spcr_r  <= fmul(sp, cr);
    sr1_r   <= sr;
    cr1_r   <= cr;
    cp1_r   <= cp;
  end

  // triple products, the rest is carried along
  always_ff @(posedge clk) begin
    a_r      <= fmul(sycp_r, sr1_r);
    b_r      <= fmul(sycp_r, cr1_r);
    c_r      <= fmul(cycp_r, sr1_r);
    d_r      <= fmul(cycp_r, cr1_r);
    cycr2_r  <= cycr_r;
    ncysr2_r <= ncysr_r;
    sysp2_r  <= sysp_r;
    nsysr2_r <= nsysr_r;
    sycr2_r  <= sycr_r;
    ncysp2_r <= ncysp_r;
    spsr2_r  <= spsr_r;
    spcr2_r  <= spcr_r;
    cp2_r    <= cp1_r;
  end

  function automatic trig_t sat(input logic signed [VAL_W:0] v);
    if (v > (VAL_W+1)'(LIM))       return LIM;
    else if (v < -(VAL_W+1)'(LIM)) return -LIM;
    else                           return VAL_W'(v);
  endfunction

  // sums and saturation
  always_comb begin
    e00 = (VAL_W+1)'(cycr2_r)  - (VAL_W+1)'(a_r);
    e01 = (VAL_W+1)'(ncysr2_r) - (VAL_W+1)'(b_r);
    e10 = (VAL_W+1)'(sycr2_r)  + (VAL_W+1)'(c_r);
    e11 = (VAL_W+1)'(nsysr2_r) + (VAL_W+1)'(d_r);
    res_nxt.m_r0c0 = sat(e00);
    res_nxt.m_r0c1 = sat(e01);
    res_nxt.m_r0c2 = sat((VAL_W+1)'(sysp2_r));
    res_nxt.m_r1c0 = sat(e10);
    res_nxt.m_r1c1 = sat(e11);
    res_nxt.m_r1c2 = sat((VAL_W+1)'(ncysp2_r));
    res_nxt.m_r2c0 = sat((VAL_W+1)'(spsr2_r));
    res_nxt.m_r2c1 = sat((VAL_W+1)'(spcr2_r));
    res_nxt.m_r2c2 = sat((VAL_W+1)'(cp2_r));
  end

  always_ff @(posedge clk) begin
    out_result <= res_nxt;
  end

endmodule

// ===== dv/euler_zxz_rotation_matrix_chk.sv =====
// ----------------------------------------------------------------------------
// euler_zxz_rotation_matrix_chk
// Watches the request and result channels, works out the expected matrix
// for each accepted angle triple and compares every result entry by entry.
// ----------------------------------------------------------------------------
module euler_zxz_rotation_matrix_chk (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_start,
  input  logic              in_busy,
  input  ezr_pkg::ezr_in_t  in_req,
  input  logic              out_valid,
  input  ezr_pkg::ezr_out_t out_result,
  output int                err_count,
  output int                pending,
  output int                matched
);
  timeunit 1ns;
  timeprecision 1ps;
  import ezr_pkg::*;

  localparam logic [63:0] TWO_PI_Q60 = 64'h6487ED5110B4611A;
  localparam logic [63:0] ONE_Q62    = 64'h4000000000000000;

  ezr_out_t matrix_q[$];

  function automatic logic [63:0] mul_q62(input logic [63:0] a, input logic [63:0] b);
    logic [127:0] p;
    p = {64'd0, a} * {64'd0, b};
    return p[125:62];
  endfunction

  // sine and cosine magnitudes in q62 for 0 <= r <= eighth turn
  function automatic void octant_trig(input logic [63:0] r, output logic [63:0] s,
                                      output logic [63:0] c);
    logic [127:0] p;
    logic [63:0] t, t2, term, sum;
    p = {64'd0, r} * {64'd0, TWO_PI_Q60};
    t = p[ANGLE_BITS-2 +: 64];
    t2 = mul_q62(t, t);
    term = t; sum = t;
    for (int k = 1; k <= 16; k++) begin
      term = mul_q62(term, t2) / 64'((2 * k) * (2 * k + 1));
      if (k & 1) sum = sum - term; else sum = sum + term;
    end
    s = sum;
    term = ONE_Q62; sum = ONE_Q62;
    for (int k = 1; k <= 16; k++) begin
      term = mul_q62(term, t2) / 64'((2 * k - 1) * (2 * k));
      if (k & 1) sum = sum - term; else sum = sum + term;
    end
    c = sum;
  endfunction

  function automatic longint round_q14(input logic [63:0] v);
    return longint'((v + (64'd1 << (61 - FRAC_BITS))) >> (62 - FRAC_BITS));
  endfunction

  function automatic void angle_trig(input logic [ANGLE_BITS-1:0] a, output longint sn,
                                     output longint cs);
    logic [63:0] r, sm, cm;
    longint s, c;
    r = 64'(a[ANGLE_BITS-3:0]);
    if (r <= (64'd1 << (ANGLE_BITS - 3))) begin
      octant_trig(r, sm, cm);
      s = round_q14(sm); c = round_q14(cm);
    end else begin
      octant_trig((64'd1 << (ANGLE_BITS - 2)) - r, sm, cm);
      s = round_q14(cm); c = round_q14(sm);
    end
    case (a[ANGLE_BITS-1 -: 2])
      2'd0: begin sn = s;  cs = c;  end
      2'd1: begin sn = c;  cs = -s; end
      2'd2: begin sn = -s; cs = -c; end
      default: begin sn = -c; cs = s; end
    endcase
  endfunction

  function automatic longint qmul(input longint a, input longint b);
    return (a * b) >>> FRAC_BITS;
  endfunction

  function automatic trig_t clamp(input longint v);
    longint lim;
    lim = longint'(1) << FRAC_BITS;
    if (v > lim) v = lim;
    if (v < -lim) v = -lim;
    return trig_t'(v);
  endfunction

  function automatic ezr_out_t zxz_matrix(input ezr_in_t req);
    longint sy, cy, sp, cp, sr, cr;
    ezr_out_t m;
    angle_trig(req.yaw_angle, sy, cy);
    angle_trig(req.pitch_angle, sp, cp);
    angle_trig(req.roll_angle, sr, cr);
    m.m_r0c0 = clamp(qmul(cy, cr) - qmul(qmul(sy, cp), sr));
    m.m_r0c1 = clamp(qmul(-cy, sr) - qmul(qmul(sy, cp), cr));
    m.m_r0c2 = clamp(qmul(sy, sp));
    m.m_r1c0 = clamp(qmul(sy, cr) + qmul(qmul(cy, cp), sr));
    m.m_r1c1 = clamp(qmul(-sy, sr) + qmul(qmul(cy, cp), cr));
    m.m_r1c2 = clamp(qmul(-cy, sp));
    m.m_r2c0 = clamp(qmul(sp, sr));
    m.m_r2c1 = clamp(qmul(sp, cr));
    m.m_r2c2 = clamp(cp);
    return m;
  endfunction

  task automatic cmp(input string name, input trig_t exp_v, input trig_t act_v);
    if (exp_v !== act_v) begin
      $error("%s: expected %0d, got %0d", name, exp_v, act_v);
      err_count++;
    end
  endtask

  initial begin
    err_count = 0;
    matched = 0;
    pending = 0;
  end

  always @(posedge clk) begin
    ezr_out_t e;
    if (rst_n) begin
      if (in_start && !in_busy) matrix_q.push_back(zxz_matrix(in_req));
      if (out_valid) begin
        if (matrix_q.size() == 0) begin
          $error("result with no request outstanding");
          err_count++;
        end else begin
          e = matrix_q.pop_front();
          cmp("m_r0c0", e.m_r0c0, out_result.m_r0c0);
          cmp("m_r0c1", e.m_r0c1, out_result.m_r0c1);
          cmp("m_r0c2", e.m_r0c2, out_result.m_r0c2);
          cmp("m_r1c0", e.m_r1c0, out_result.m_r1c0);
          cmp("m_r1c1", e.m_r1c1, out_result.m_r1c1);
          cmp("m_r1c2", e.m_r1c2, out_result.m_r1c2);
          cmp("m_r2c0", e.m_r2c0, out_result.m_r2c0);
          cmp("m_r2c1", e.m_r2c1, out_result.m_r2c1);
          cmp("m_r2c2", e.m_r2c2, out_result.m_r2c2);
          matched++;
        end
      end
    end
    pending = matrix_q.size();
  end
endmodule

// ===== dv/euler_zxz_rotation_matrix_tb.sv =====
// ----------------------------------------------------------------------------
// euler_zxz_rotation_matrix_tb
// Drives angle triples into the rotation matrix block, directed corners first
// (zero, quarter and eighth turns, all-ones angles), then random triples with
// and without idle gaps; the checker predicts and compares every matrix.
// ----------------------------------------------------------------------------
module euler_zxz_rotation_matrix_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import ezr_pkg::*;

  localparam int N_RANDOM  = 1800;
  localparam int MAX_CYCLE = 300000;
  localparam int DRAIN     = SC_LAT + 20;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_start = 1'b0;
  logic in_busy;
  ezr_in_t in_req = '0;
  logic out_valid;
  ezr_out_t out_result;
  int err_count, pending, matched;
  int cycle_cnt = 0;
  int idle_pct = 0;

  // free-running clock, 10 ns period
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  euler_zxz_rotation_matrix i_dut (
    .clk(clk), .rst_n(rst_n), .in_start(in_start), .in_busy(in_busy),
    .in_req(in_req), .out_valid(out_valid), .out_result(out_result)
  );

  euler_zxz_rotation_matrix_chk i_chk (
    .clk(clk), .rst_n(rst_n), .in_start(in_start), .in_busy(in_busy),
    .in_req(in_req), .out_valid(out_valid), .out_result(out_result),
    .err_count(err_count), .pending(pending), .matched(matched)
  );

  // watchdog: runaway run is a failure
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > MAX_CYCLE) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // random angle, biased toward quarter and eighth turns and their neighbors
  function automatic logic [ANGLE_BITS-1:0] pick_angle();
    logic [ANGLE_BITS-1:0] a;
    case ($urandom_range(0, 9))
      0: a = ANGLE_BITS'($urandom_range(0, 7)) << (ANGLE_BITS - 3);
      1: a = (ANGLE_BITS'($urandom_range(0, 7)) << (ANGLE_BITS - 3))
             + ANGLE_BITS'($urandom_range(0, 6)) - ANGLE_BITS'(3);
      default: a = ANGLE_BITS'($urandom);
    endcase
    return a;
  endfunction

  // one request; each cycle idles with probability idle_pct percent
  task automatic send_req(input ezr_in_t req);
    while (idle_pct > 0 && $urandom_range(0, 99) < idle_pct) begin
      in_start <= 1'b0;
      @(posedge clk);
    end
    in_start <= 1'b1;
    in_req <= req;
    do @(posedge clk); while (in_busy);
  endtask

  initial begin
    ezr_in_t r;
    logic [ANGLE_BITS-1:0] corner [8];
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed corners: zero, eighth, quarter, half, all ones
    corner = '{16'h0000, 16'h2000, 16'h4000, 16'h8000, 16'hC000, 16'hE000,
               16'hFFFF, 16'h0001};
    for (int i = 0; i < 8; i++) begin
      send_req('{corner[i], corner[(i + 3) % 8], corner[(i + 5) % 8]});
      send_req('{corner[i], corner[i], corner[i]});
    end
    send_req('{16'h2001, 16'h1FFF, 16'h6000});
    send_req('{16'hA000, 16'h4000, 16'h3FFF});

    // random phases: sender idles 36%, then 55%, then never
    for (int ph = 0; ph < 3; ph++) begin
      idle_pct = (ph == 0) ? 36 : (ph == 1) ? 55 : 0;
      for (int i = 0; i < N_RANDOM / 3; i++) begin
        r.yaw_angle = pick_angle();
        r.pitch_angle = pick_angle();
        r.roll_angle = pick_angle();
        send_req(r);
      end
    end
    in_start <= 1'b0;

    while (pending != 0) @(posedge clk);
    repeat (DRAIN) @(posedge clk);

    $display("covered %0d matrices: corner angles plus random triples", matched);
    $display("idle mixes of 36%%, 55%% and 0%% on the request side");
    if (err_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end
endmodule
